/* rtl/isots_pkg.sv */
// ----------------------------------------------------------------------------
// isots_pkg
// Shared types, codes, text positions and the month table of the timestamp
// parser.
// ----------------------------------------------------------------------------
package isots_pkg;

    localparam int UtcW = 39;
    localparam int OfsW = 18;
    localparam int DayW = 23;

    typedef logic [4:0] t_pos;
    typedef logic [2:0] t_status;
    typedef logic [1:0] t_zone;

    localparam t_status StatusOk       = 3'd0;
    localparam t_status StatusShort    = 3'd1;
    localparam t_status StatusNonDigit = 3'd2;
    localparam t_status StatusRange    = 3'd3;
    localparam t_status StatusZone     = 3'd4;

    localparam t_zone ZoneZ     = 2'd0;
    localparam t_zone ZonePlus  = 2'd1;
    localparam t_zone ZoneMinus = 2'd2;

    // Text positions at which the time unit folds a finished field in
    localparam t_pos PosYearDiv   = 5'd4;
    localparam t_pos PosLeap      = 5'd5;
    localparam t_pos PosYearDays  = 5'd6;
    localparam t_pos PosMonthDays = 5'd7;
    localparam t_pos PosDayDays   = 5'd10;
    localparam t_pos PosDaySecs   = 5'd11;
    localparam t_pos PosHourSecs  = 5'd13;
    localparam t_pos PosMinSecs   = 5'd16;
    localparam t_pos PosMarker    = 5'd19;
    localparam t_pos PosZoneHour  = 5'd22;
    localparam t_pos PosZoneEnd   = 5'd24;

    // Field values and per-byte results handed from the field unit
    typedef struct packed {
        t_pos        pos;
        logic [13:0] year;
        logic [6:0]  month;
        logic [6:0]  day;
        logic [6:0]  hour;
        logic [6:0]  minute;
        logic [6:0]  second;
        logic [6:0]  zone_hour;
        logic [6:0]  zone_minute_next;
        t_zone       sign;
        t_status     status;
    } t_fld;

    function automatic logic [8:0] days_before_month(input logic [3:0] idx);
        logic [8:0] v;
        case (idx)
            4'd0:    v = 9'd0;
            4'd1:    v = 9'd31;
            4'd2:    v = 9'd59;
            4'd3:    v = 9'd90;
            4'd4:    v = 9'd120;
            4'd5:    v = 9'd151;
            4'd6:    v = 9'd181;
            4'd7:    v = 9'd212;
            4'd8:    v = 9'd243;
            4'd9:    v = 9'd273;
            4'd10:   v = 9'd304;
            4'd11:   v = 9'd334;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

endpackage

/* rtl/isots_field.sv */
// ----------------------------------------------------------------------------
// isots_field
// Byte position counter, digit accumulators, zone marker and first-error
// tracking; forms the status of the current byte.
// ----------------------------------------------------------------------------
module isots_field (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_go,
    input  logic [7:0]        i_char,
    input  logic              i_last,
    output isots_pkg::t_fld   o_fld
);

    localparam logic [7:0] CharZero  = 8'h30;
    localparam logic [7:0] CharZ     = 8'h5A;
    localparam logic [7:0] CharPlus  = 8'h2B;
    localparam logic [7:0] CharMinus = 8'h2D;

    isots_pkg::t_pos    r_pos, n_pos;
    logic [13:0]        r_year, n_year;
    logic [6:0]         r_month, n_month;
    logic [6:0]         r_day, n_day;
    logic [6:0]         r_hour, n_hour;
    logic [6:0]         r_minute, n_minute;
    logic [6:0]         r_second, n_second;
    logic [6:0]         r_zone_hour, n_zone_hour;
    logic [6:0]         r_zone_minute, n_zone_minute;
    isots_pkg::t_zone   r_sign, n_sign;
    isots_pkg::t_status r_err, n_err;

    logic               w_dg;
    logic [3:0]         w_d;
    logic               w_zoned;
    logic [13:0]        w_new_year;
    logic [6:0]         w_sel7;
    logic [6:0]         w_new7;
    logic               w_digit;
    logic               w_chk;
    logic [13:0]        w_lo;
    logic [13:0]        w_hi;
    logic [13:0]        w_val;
    logic               w_bad_marker;
    isots_pkg::t_status w_flag;
    isots_pkg::t_status w_status;

    assign w_dg       = i_char inside {[8'h30:8'h39]};
    assign w_d        = w_dg ? 4'(i_char - CharZero) : 4'd0;
    assign w_zoned    = r_sign != isots_pkg::ZoneZ;
    assign w_new_year = w_dg ? r_year * 14'd10 + 14'(w_d) : r_year;
    assign w_new7     = w_dg ? w_sel7 * 7'd10 + 7'(w_d) : w_sel7;

    always_comb begin
        case (r_pos)
            5'd5, 5'd6:   w_sel7 = r_month;
            5'd8, 5'd9:   w_sel7 = r_day;
            5'd11, 5'd12: w_sel7 = r_hour;
            5'd14, 5'd15: w_sel7 = r_minute;
            5'd17, 5'd18: w_sel7 = r_second;
            5'd20, 5'd21: w_sel7 = r_zone_hour;
            5'd23, 5'd24: w_sel7 = r_zone_minute;
            default:      w_sel7 = 7'd0;
        endcase
    end

    always_comb begin
        n_year        = r_year;
        n_month       = r_month;
        n_day         = r_day;
        n_hour        = r_hour;
        n_minute      = r_minute;
        n_second      = r_second;
        n_zone_hour   = r_zone_hour;
        n_zone_minute = r_zone_minute;
        n_sign        = r_sign;
        w_digit       = 1'b0;
        w_chk         = 1'b0;
        w_lo          = 14'd0;
        w_hi          = 14'd0;
        w_val         = {7'd0, w_new7};
        w_bad_marker  = 1'b0;
        case (r_pos)
            5'd0, 5'd1, 5'd2: begin
                w_digit = 1'b1;
                n_year  = w_new_year;
            end
            5'd3: begin
                w_digit = 1'b1;
                n_year  = w_new_year;
                w_chk   = 1'b1;
                w_lo    = 14'd1900;
                w_hi    = 14'd9999;
                w_val   = w_new_year;
            end
            5'd5: begin
                w_digit = 1'b1;
                n_month = w_new7;
            end
            5'd6: begin
                w_digit = 1'b1;
                n_month = w_new7;
                w_chk   = 1'b1;
                w_lo    = 14'd1;
                w_hi    = 14'd12;
            end
            5'd8: begin
                w_digit = 1'b1;
                n_day   = w_new7;
            end
            5'd9: begin
                w_digit = 1'b1;
                n_day   = w_new7;
                w_chk   = 1'b1;
                w_lo    = 14'd1;
                w_hi    = 14'd31;
            end
            5'd11: begin
                w_digit = 1'b1;
                n_hour  = w_new7;
            end
            5'd12: begin
                w_digit = 1'b1;
                n_hour  = w_new7;
                w_chk   = 1'b1;
                w_hi    = 14'd23;
            end
            5'd14: begin
                w_digit  = 1'b1;
                n_minute = w_new7;
            end
            5'd15: begin
                w_digit  = 1'b1;
                n_minute = w_new7;
                w_chk    = 1'b1;
                w_hi     = 14'd59;
            end
            5'd17: begin
                w_digit  = 1'b1;
                n_second = w_new7;
            end
            5'd18: begin
                w_digit  = 1'b1;
                n_second = w_new7;
                w_chk    = 1'b1;
                w_hi     = 14'd59;
            end
            isots_pkg::PosMarker: begin
                if (i_char == CharZ) begin
                    n_sign = isots_pkg::ZoneZ;
                end else if (i_char == CharPlus) begin
                    n_sign = isots_pkg::ZonePlus;
                end else if (i_char == CharMinus) begin
                    n_sign = isots_pkg::ZoneMinus;
                end else begin
                    w_bad_marker = 1'b1;
                end
            end
            5'd20: begin
                if (w_zoned) begin
                    w_digit     = 1'b1;
                    n_zone_hour = w_new7;
                end
            end
            5'd21: begin
                if (w_zoned) begin
                    w_digit     = 1'b1;
                    n_zone_hour = w_new7;
                    w_chk       = 1'b1;
                    w_hi        = 14'd23;
                end
            end
            5'd23: begin
                if (w_zoned) begin
                    w_digit       = 1'b1;
                    n_zone_minute = w_new7;
                end
            end
            isots_pkg::PosZoneEnd: begin
                if (w_zoned) begin
                    w_digit       = 1'b1;
                    n_zone_minute = w_new7;
                    w_chk         = 1'b1;
                    w_hi          = 14'd59;
                end
            end
            default: ;
        endcase
    end

    // A non-digit outranks the range check of the same byte
    always_comb begin
        if (w_digit && !w_dg) begin
            w_flag = isots_pkg::StatusNonDigit;
        end else if (w_chk && (w_val < w_lo || w_val > w_hi)) begin
            w_flag = isots_pkg::StatusRange;
        end else if (w_bad_marker) begin
            w_flag = isots_pkg::StatusZone;
        end else begin
            w_flag = isots_pkg::StatusOk;
        end
    end

    assign n_err = (r_err != isots_pkg::StatusOk) ? r_err : w_flag;
    assign n_pos = (&r_pos) ? r_pos : r_pos + 5'd1;

    always_comb begin
        if (r_pos < isots_pkg::PosMarker) begin
            w_status = isots_pkg::StatusShort;
        end else if (n_err != isots_pkg::StatusOk) begin
            w_status = n_err;
        end else if (n_sign != isots_pkg::ZoneZ && r_pos < isots_pkg::PosZoneEnd) begin
            w_status = isots_pkg::StatusShort;
        end else begin
            w_status = isots_pkg::StatusOk;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_go && i_last)) begin
            r_pos         <= '0;
            r_year        <= '0;
            r_month       <= '0;
            r_day         <= '0;
            r_hour        <= '0;
            r_minute      <= '0;
            r_second      <= '0;
            r_zone_hour   <= '0;
            r_zone_minute <= '0;
            r_sign        <= isots_pkg::ZoneZ;
            r_err         <= isots_pkg::StatusOk;
        end else if (i_go) begin
            r_pos         <= n_pos;
            r_year        <= n_year;
            r_month       <= n_month;
            r_day         <= n_day;
            r_hour        <= n_hour;
            r_minute      <= n_minute;
            r_second      <= n_second;
            r_zone_hour   <= n_zone_hour;
            r_zone_minute <= n_zone_minute;
            r_sign        <= n_sign;
            r_err         <= n_err;
        end
    end

    always_comb begin
        o_fld.pos              = r_pos;
        o_fld.year             = r_year;
        o_fld.month            = r_month;
        o_fld.day              = r_day;
        o_fld.hour             = r_hour;
        o_fld.minute           = r_minute;
        o_fld.second           = r_second;
        o_fld.zone_hour        = r_zone_hour;
        o_fld.zone_minute_next = n_zone_minute;
        o_fld.sign             = r_sign;
        o_fld.status           = w_status;
    end

endmodule

/* rtl/isots_time.sv */
// ----------------------------------------------------------------------------
// isots_time
// Builds the day count and the UTC second count step by step as later bytes
// arrive, one finished field folded in at a fixed text position.
// ----------------------------------------------------------------------------
module isots_time (
    input  logic                                 i_clk,
    input  logic                                 i_go,
    input  isots_pkg::t_fld                      i_fld,
    output logic signed [isots_pkg::UtcW-1:0]    o_utc,
    output logic signed [isots_pkg::OfsW-1:0]    o_offset
);

    localparam logic signed [17:0] SecsPerDay = 18'sd86400;

    logic [7:0]                          r_yq100;
    logic [7:0]                          r_pq100;
    logic                                r_leap;
    logic signed [isots_pkg::DayW-1:0]   r_days, n_days;
    logic signed [isots_pkg::UtcW-1:0]   r_secs, n_secs;
    logic [18:0]                         r_ofs, n_ofs;

    logic [26:0]                         w_yq_prod;
    logic [13:0]                         w_rem;
    logic [13:0]                         w_py;
    logic signed [23:0]                  w_year_days;
    logic [3:0]                          w_month_idx;
    logic [9:0]                          w_month_days;
    logic signed [40:0]                  w_day_prod;
    logic [18:0]                         w_hour_secs;
    logic [12:0]                         w_min_secs;
    logic [18:0]                         w_zh_secs;
    logic [12:0]                         w_zm_secs;
    logic [18:0]                         w_ofs_mag;
    logic signed [19:0]                  w_ofs_s;

    // year / 100 by reciprocal, exact for every 14-bit year below 43699
    assign w_yq_prod = 27'(i_fld.year) * 27'd5243;
    assign w_rem     = i_fld.year - 14'(r_yq100) * 14'd100;
    assign w_py      = i_fld.year - 14'd1;

    assign w_year_days = ($signed({10'd0, i_fld.year}) - 24'sd1970) * 24'sd365
                       + $signed({12'd0, w_py[13:2]})
                       - $signed({16'd0, r_pq100})
                       + $signed({18'd0, r_pq100[7:2]})
                       - 24'sd477;

    assign w_month_idx  = i_fld.month[3:0] - 4'd1;
    assign w_month_days = {1'b0, isots_pkg::days_before_month(w_month_idx)}
                        + {9'd0, r_leap && (i_fld.month > 7'd2)};

    assign w_day_prod  = r_days * SecsPerDay;
    assign w_hour_secs = 19'(i_fld.hour) * 19'd3600;
    assign w_min_secs  = 13'(i_fld.minute) * 13'd60;
    assign w_zh_secs   = 19'(i_fld.zone_hour) * 19'd3600;
    assign w_zm_secs   = 13'(i_fld.zone_minute_next) * 13'd60;

    // Zone minutes finish on the closing byte itself: add them in on the fly
    assign w_ofs_mag = (i_fld.pos == isots_pkg::PosZoneEnd) ? r_ofs + 19'(w_zm_secs) : r_ofs;

    always_comb begin
        if (i_fld.sign == isots_pkg::ZoneMinus) begin
            w_ofs_s = -$signed({1'b0, w_ofs_mag});
        end else if (i_fld.sign == isots_pkg::ZonePlus) begin
            w_ofs_s = $signed({1'b0, w_ofs_mag});
        end else begin
            w_ofs_s = 20'sd0;
        end
    end

    always_comb begin
        n_days = r_days;
        n_secs = r_secs;
        n_ofs  = r_ofs;
        case (i_fld.pos)
            isots_pkg::PosYearDays:  n_days = w_year_days[isots_pkg::DayW-1:0];
            isots_pkg::PosMonthDays: n_days = r_days + $signed({13'd0, w_month_days});
            isots_pkg::PosDayDays:   n_days = r_days + $signed({16'd0, i_fld.day}) - 23'sd1;
            isots_pkg::PosDaySecs:   n_secs = w_day_prod[isots_pkg::UtcW-1:0];
            isots_pkg::PosHourSecs:  n_secs = r_secs + $signed({20'd0, w_hour_secs});
            isots_pkg::PosMinSecs:   n_secs = r_secs + $signed({26'd0, w_min_secs});
            isots_pkg::PosMarker:    n_secs = r_secs + $signed({32'd0, i_fld.second});
            isots_pkg::PosZoneHour: begin
                if (i_fld.sign != isots_pkg::ZoneZ) begin
                    n_ofs = w_zh_secs;
                end
            end
            isots_pkg::PosZoneEnd: begin
                n_secs = r_secs - 39'(w_ofs_s);
                n_ofs  = w_ofs_mag;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            if (i_fld.pos == isots_pkg::PosYearDiv) begin
                r_yq100 <= w_yq_prod[26:19];
            end
            if (i_fld.pos == isots_pkg::PosLeap) begin
                r_leap  <= (i_fld.year[1:0] == 2'd0) && ((w_rem != 14'd0) || (r_yq100[1:0] == 2'd0));
                r_pq100 <= (w_rem == 14'd0) ? r_yq100 - 8'd1 : r_yq100;
            end
            r_days <= n_days;
            r_secs <= n_secs;
            r_ofs  <= n_ofs;
        end
    end

    assign o_utc    = n_secs;
    assign o_offset = 18'(w_ofs_s);

endmodule

/* rtl/iso8601_timestamp_parser.sv */
// ----------------------------------------------------------------------------
// iso8601_timestamp_parser
// Reads an ISO 8601 date-time text one byte per request and gives status,
// UTC Unix seconds and zone offset on the closing byte.
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+------------------------------------
//  in      | input     | i_in_valid / o_in_stall | i_char_code, i_last_char
//  out     | output    | o_out_valid/i_out_stall | o_status, o_utc_seconds,
//          |           |                         | o_offset_seconds
//
//  One byte a cycle while no closing byte is held back. A byte is captured in
//  the input register; when it goes on it updates the field and time units
//  and, if closing, loads the result register.
//  The day and second sums are built over the byte positions of the text, one
//  finished field folded in per byte, so no byte sees more than one multiply.
//  Synchronous active-low reset empties both registers and clears all fields.
//  A stalled result holds only closing bytes back; other bytes go on.
// ----------------------------------------------------------------------------
module iso8601_timestamp_parser (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [7:0]                           i_char_code,
    input  logic                                 i_last_char,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [2:0]                           o_status,
    output logic signed [isots_pkg::UtcW-1:0]    o_utc_seconds,
    output logic signed [isots_pkg::OfsW-1:0]    o_offset_seconds
);

    logic                                r_a_valid;
    logic [7:0]                          r_a_char;
    logic                                r_a_last;
    logic                                r_out_valid;
    isots_pkg::t_status                  r_status;
    logic signed [isots_pkg::UtcW-1:0]   r_utc;
    logic signed [isots_pkg::OfsW-1:0]   r_ofs;

    logic                                w_out_ready;
    logic                                w_go;
    logic                                w_a_free;
    isots_pkg::t_fld                     w_fld;
    logic signed [isots_pkg::UtcW-1:0]   w_utc;
    logic signed [isots_pkg::OfsW-1:0]   w_ofs;
    logic                                w_ok;

    assign w_out_ready = !r_out_valid || !i_out_stall;
    assign w_go        = r_a_valid && (!r_a_last || w_out_ready);
    assign w_a_free    = !r_a_valid || w_go;
    assign o_in_stall  = !w_a_free;
    assign w_ok        = w_fld.status == isots_pkg::StatusOk;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_a_free) begin
            r_a_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_a_free && i_in_valid) begin
            r_a_char <= i_char_code;
            r_a_last <= i_last_char;
        end
    end

    isots_field u_field (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (w_go),
        .i_char  (r_a_char),
        .i_last  (r_a_last),
        .o_fld   (w_fld)
    );

    isots_time u_time (
        .i_clk    (i_clk),
        .i_go     (w_go),
        .i_fld    (w_fld),
        .o_utc    (w_utc),
        .o_offset (w_ofs)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_go && r_a_last) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Zero the numbers of a failed text
    always_ff @(posedge i_clk) begin
        if (w_go && r_a_last) begin
            r_status <= w_fld.status;
            r_utc    <= w_ok ? w_utc : '0;
            r_ofs    <= w_ok ? w_ofs : '0;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_status;
    assign o_utc_seconds    = r_utc;
    assign o_offset_seconds = r_ofs;

    a_rise_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(w_go && r_a_last))
        else $error("result appeared without a closing byte");

    a_fail_zeroed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status != isots_pkg::StatusOk) |->
            (r_utc == '0 && r_ofs == '0))
        else $error("failed text carries non-zero numbers");

    a_pos_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_go && r_a_last) |=> (w_fld.pos == '0))
        else $error("position not restarted after closing byte");

    a_hold_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && !w_go) |=> (r_a_valid && $stable(r_a_char) && $stable(r_a_last)))
        else $error("held byte overwritten");

endmodule

/* tb/iso8601_timestamp_parser_tb.sv */
// ----------------------------------------------------------------------------
// iso8601_timestamp_parser_tb
// Feeds date-time texts byte by byte through the parser and checks every
// status, UTC stamp and zone offset against bench predictions or pinned values.
// A directed table covers field extremes, each error code and the zone rules.
// Random texts follow, mostly well formed with random content, some corrupted,
// cut short, padded or pure noise. Both channels idle at random, and the
// result side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module iso8601_timestamp_parser_tb;

    localparam int ITEMS       = 1800;
    localparam int HOLD_CYCLES = 300;
    localparam int QUIET_LIMIT = 4000;
    localparam int TAIL_CYCLES = 8;
    localparam int DIR_N       = 29;

    localparam int MONTH_START [0:11] = '{
        0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334
    };

    typedef struct packed {
        isots_pkg::t_status         status;
        logic [isots_pkg::UtcW-1:0] utc;
        logic [isots_pkg::OfsW-1:0] ofs;
    } t_stamp;

    typedef struct {
        string              text;
        bit                 pinned;
        isots_pkg::t_status status;
        longint             utc;
        int                 ofs;
    } t_text_row;

    logic                              i_clk       = 1'b0;
    logic                              i_rst_n     = 1'b0;
    logic                              i_in_valid  = 1'b0;
    logic [7:0]                        i_char_code = 8'd0;
    logic                              i_last_char = 1'b0;
    logic                              i_out_stall = 1'b0;
    logic                              o_in_stall;
    logic                              o_out_valid;
    logic [2:0]                        o_status;
    logic signed [isots_pkg::UtcW-1:0] o_utc_seconds;
    logic signed [isots_pkg::OfsW-1:0] o_offset_seconds;

    iso8601_timestamp_parser u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_char_code      (i_char_code),
        .i_last_char      (i_last_char),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_status         (o_status),
        .o_utc_seconds    (o_utc_seconds),
        .o_offset_seconds (o_offset_seconds)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Parser state as the bench sees it
    isots_pkg::t_pos    p_pos   = '0;
    logic [13:0]        p_year  = '0;
    logic [6:0]         p_mon   = '0;
    logic [6:0]         p_day   = '0;
    logic [6:0]         p_hour  = '0;
    logic [6:0]         p_min   = '0;
    logic [6:0]         p_sec   = '0;
    logic [6:0]         p_zhour = '0;
    logic [6:0]         p_zmin  = '0;
    isots_pkg::t_zone   p_sign  = isots_pkg::ZoneZ;
    isots_pkg::t_status p_fault = isots_pkg::StatusOk;

    t_stamp      stamp_q [$];
    logic [7:0]  txt_q [$];
    t_text_row   dir_tab [0:DIR_N-1];
    bit          pin_en = 1'b0;
    t_stamp      pin_stamp;
    bit          gappy = 1'b0;
    bit          hold_req = 1'b0;
    int          hold_left = 0;
    int          faults = 0;
    int          n_bytes = 0;
    int          n_texts = 0;
    int          n_stamps = 0;
    int          status_seen [0:4] = '{0, 0, 0, 0, 0};

    function automatic void flag_fault(input isots_pkg::t_status code);
        if (p_fault == isots_pkg::StatusOk)
            p_fault = code;
    endfunction

    function automatic longint days_from_epoch(input longint y, input longint m,
                                               input longint d);
        longint py;
        longint days;
        bit     leap;
        py   = y - 1;
        days = 365 * (y - 1970) + py / 4 - py / 100 + py / 400 - 477;
        leap = ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
        days += MONTH_START[m - 1];
        if (leap && m > 2)
            days += 1;
        return days + d - 1;
    endfunction

    // Fold one accepted byte into the parse and queue the stamp on a closing byte
    task automatic parse_byte(input logic [7:0] c, input logic lst);
        logic               dg;
        logic [3:0]         dv;
        logic               zoned;
        logic               dig_pos;
        logic [5:0]         count;
        isots_pkg::t_status st;
        longint             y, m, d, ofs_s, t;
        t_stamp             s;
        dg      = (c >= 8'h30) && (c <= 8'h39);
        dv      = dg ? 4'(c - 8'h30) : 4'd0;
        zoned   = (p_sign != isots_pkg::ZoneZ);
        dig_pos = 1'b1;
        count   = {1'b0, p_pos} + 6'd1;
        case (p_pos)
            5'd0, 5'd1, 5'd2, 5'd3: if (dg) p_year = p_year * 14'd10 + 14'(dv);
            5'd5, 5'd6:   if (dg) p_mon  = p_mon * 7'd10 + 7'(dv);
            5'd8, 5'd9:   if (dg) p_day  = p_day * 7'd10 + 7'(dv);
            5'd11, 5'd12: if (dg) p_hour = p_hour * 7'd10 + 7'(dv);
            5'd14, 5'd15: if (dg) p_min  = p_min * 7'd10 + 7'(dv);
            5'd17, 5'd18: if (dg) p_sec  = p_sec * 7'd10 + 7'(dv);
            5'd20, 5'd21: begin
                dig_pos = zoned;
                if (zoned && dg) p_zhour = p_zhour * 7'd10 + 7'(dv);
            end
            5'd23, isots_pkg::PosZoneEnd: begin
                dig_pos = zoned;
                if (zoned && dg) p_zmin = p_zmin * 7'd10 + 7'(dv);
            end
            isots_pkg::PosMarker: begin
                dig_pos = 1'b0;
                if (c == "Z")      p_sign = isots_pkg::ZoneZ;
                else if (c == "+") p_sign = isots_pkg::ZonePlus;
                else if (c == "-") p_sign = isots_pkg::ZoneMinus;
                else               flag_fault(isots_pkg::StatusZone);
            end
            default: dig_pos = 1'b0;
        endcase
        if (dig_pos && !dg)
            flag_fault(isots_pkg::StatusNonDigit);
        // Range check on the closing digit of each field
        case (p_pos)
            5'd3:  if (p_year < 14'd1900 || p_year > 14'd9999)
                       flag_fault(isots_pkg::StatusRange);
            5'd6:  if (p_mon < 7'd1 || p_mon > 7'd12) flag_fault(isots_pkg::StatusRange);
            5'd9:  if (p_day < 7'd1 || p_day > 7'd31) flag_fault(isots_pkg::StatusRange);
            5'd12: if (p_hour > 7'd23) flag_fault(isots_pkg::StatusRange);
            5'd15: if (p_min > 7'd59) flag_fault(isots_pkg::StatusRange);
            5'd18: if (p_sec > 7'd59) flag_fault(isots_pkg::StatusRange);
            5'd21: if (zoned && p_zhour > 7'd23) flag_fault(isots_pkg::StatusRange);
            isots_pkg::PosZoneEnd: if (zoned && p_zmin > 7'd59)
                                       flag_fault(isots_pkg::StatusRange);
            default: ;
        endcase
        if (p_pos != 5'd31)
            p_pos = p_pos + 5'd1;

        if (lst) begin
            if (count < 6'd20)
                st = isots_pkg::StatusShort;
            else if (p_fault != isots_pkg::StatusOk)
                st = p_fault;
            else if (p_sign != isots_pkg::ZoneZ && count < 6'd25)
                st = isots_pkg::StatusShort;
            else
                st = isots_pkg::StatusOk;
            s = '0;
            s.status = st;
            if (st == isots_pkg::StatusOk) begin
                ofs_s = 0;
                if (p_sign != isots_pkg::ZoneZ) begin
                    y     = p_zhour;
                    m     = p_zmin;
                    ofs_s = (y * 60 + m) * 60;
                    if (p_sign == isots_pkg::ZoneMinus)
                        ofs_s = -ofs_s;
                end
                y = p_year;
                m = p_mon;
                d = p_day;
                t = days_from_epoch(y, m, d) * 86400;
                y = p_hour;
                m = p_min;
                d = p_sec;
                t = t + y * 3600 + m * 60 + d - ofs_s;
                s.utc = t[isots_pkg::UtcW-1:0];
                s.ofs = ofs_s[isots_pkg::OfsW-1:0];
            end
            stamp_q.push_back(pin_en ? pin_stamp : s);
            pin_en  = 1'b0;
            p_pos   = '0;
            p_year  = '0;
            p_mon   = '0;
            p_day   = '0;
            p_hour  = '0;
            p_min   = '0;
            p_sec   = '0;
            p_zhour = '0;
            p_zmin  = '0;
            p_sign  = isots_pkg::ZoneZ;
            p_fault = isots_pkg::StatusOk;
        end
    endtask

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)      return 0;
        else if (r < 88) return $urandom_range(1, 3);
        else if (r < 98) return $urandom_range(4, 10);
        else             return $urandom_range(20, 40);
    endfunction

    function automatic void put_digits(input int v, input int n);
        int div;
        div = 1;
        repeat (n - 1) div *= 10;
        repeat (n) begin
            txt_q.push_back(8'h30 + 8'((v / div) % 10));
            div /= 10;
        end
    endfunction

    function automatic void put_sep(input logic [7:0] c);
        if ($urandom_range(0, 9) == 0)
            txt_q.push_back(8'($urandom_range(0, 255)));
        else
            txt_q.push_back(c);
    endfunction

    function automatic int pick_field(input int lo, input int hi);
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(0, 99);
        return $urandom_range(lo, hi);
    endfunction

    task automatic build_text();
        int yr, zk, n;
        txt_q.delete();
        if ($urandom_range(0, 15) == 0) begin
            n = $urandom_range(1, 30);
            repeat (n) txt_q.push_back(8'($urandom_range(0, 255)));
            return;
        end
        case ($urandom_range(0, 11))
            0:       yr = $urandom_range(0, 9999);
            1:       yr = 1900;
            2:       yr = 9999;
            default: yr = $urandom_range(1900, 9999);
        endcase
        put_digits(yr, 4);
        put_sep("-");
        put_digits(pick_field(1, 12), 2);
        put_sep("-");
        put_digits(pick_field(1, 31), 2);
        put_sep("T");
        put_digits(pick_field(0, 23), 2);
        put_sep(":");
        put_digits(pick_field(0, 59), 2);
        put_sep(":");
        put_digits(pick_field(0, 59), 2);
        zk = $urandom_range(0, 15);
        if (zk < 5)       txt_q.push_back("Z");
        else if (zk < 10) txt_q.push_back("+");
        else if (zk < 15) txt_q.push_back("-");
        else              txt_q.push_back(8'($urandom_range(0, 255)));
        if (zk >= 5) begin
            put_digits(pick_field(0, 23), 2);
            put_sep(":");
            put_digits(pick_field(0, 59), 2);
        end
        if ($urandom_range(0, 7) == 0)
            repeat ($urandom_range(1, 12)) txt_q.push_back(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 9) == 0)
            txt_q[$urandom_range(0, txt_q.size() - 1)] = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 9) == 0) begin
            n = $urandom_range(1, txt_q.size());
            while (txt_q.size() > n) void'(txt_q.pop_back());
        end
    endtask

    task automatic send_byte(input logic [7:0] c, input logic lst);
        int gap;
        gap = (gappy && !hold_req && hold_left == 0) ? pick_gap() : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_char_code <= c;
        i_last_char <= lst;
        do @(posedge i_clk); while (o_in_stall);
        n_bytes++;
        parse_byte(c, lst);
    endtask

    task automatic send_text();
        int k;
        for (k = 0; k < txt_q.size(); k++)
            send_byte(txt_q[k], k == txt_q.size() - 1);
        n_texts++;
    endtask

    task automatic check_stamp();
        t_stamp want;
        n_stamps++;
        if (o_status <= isots_pkg::StatusZone)
            status_seen[o_status]++;
        if (stamp_q.size() == 0) begin
            $display("%0t: unexpected result: status %0d utc %0d offset %0d", $time,
                     o_status, o_utc_seconds, o_offset_seconds);
            faults++;
        end else begin
            want = stamp_q.pop_front();
            if (o_status !== want.status) begin
                $display("%0t: status mismatch: expected %0d, got %0d", $time,
                         want.status, o_status);
                faults++;
            end
            if (o_utc_seconds !== want.utc) begin
                $display("%0t: utc mismatch: expected %0d, got %0d", $time,
                         $signed(want.utc), o_utc_seconds);
                faults++;
            end
            if (o_offset_seconds !== want.ofs) begin
                $display("%0t: offset mismatch: expected %0d, got %0d", $time,
                         $signed(want.ofs), o_offset_seconds);
                faults++;
            end
        end
    endtask

    // Result side: check each accepted result, then pick the next stall
    initial begin : drain
        int pause_left;
        int run_left;
        pause_left = 0;
        run_left   = 0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid && !i_out_stall)
                check_stamp();
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (pause_left > 0) begin
                pause_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
                if (run_left > 0)
                    run_left--;
                else if ($urandom_range(0, 3) == 0)
                    run_left = $urandom_range(0, 40);
                else
                    pause_left = pick_gap();
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no request moved for %0d cycles", $time, QUIET_LIMIT);
        $display("iso8601_timestamp_parser_tb: FAIL");
        $finish;
    end

    initial begin : stim
        int i, j;
        dir_tab = '{
            '{"1970-01-01T00:00:00Z",      1'b1, isots_pkg::StatusOk, 64'sd0, 0},
            '{"1900-01-01T00:00:00Z",      1'b1, isots_pkg::StatusOk, -64'sd2208988800, 0},
            '{"1900-01-01T00:00:00+23:59", 1'b1, isots_pkg::StatusOk, -64'sd2209075140,
              86340},
            '{"9999-12-31T23:59:59-23:59", 1'b1, isots_pkg::StatusOk, 64'sd253402387139,
              -86340},
            '{"9999-12-31T23:59:59Z",      1'b0, isots_pkg::StatusOk, 64'sd0, 0},
            '{"1970-01-01T00:00:0",        1'b1, isots_pkg::StatusShort, 64'sd0, 0},
            '{"Z",                         1'b1, isots_pkg::StatusShort, 64'sd0, 0},
            '{"1970-01-01T00:00:00+05",    1'b1, isots_pkg::StatusShort, 64'sd0, 0},
            '{"1970-13-01T00:00:00+05",    1'b1, isots_pkg::StatusRange, 64'sd0, 0},
            '{"1970-13-01T00:00",          1'b1, isots_pkg::StatusShort, 64'sd0, 0},
            '{"19a0-01-01T00:00:00Z",      1'b1, isots_pkg::StatusNonDigit, 64'sd0, 0},
            '{"19a9-13-01T00:00:00Z",      1'b1, isots_pkg::StatusNonDigit, 64'sd0, 0},
            '{"2000-01-01T2x:00:00Z",      1'b1, isots_pkg::StatusNonDigit, 64'sd0, 0},
            '{"1899-12-31T23:59:59Z",      1'b1, isots_pkg::StatusRange, 64'sd0, 0},
            '{"2000-00-10T00:00:00Z",      1'b1, isots_pkg::StatusRange, 64'sd0, 0},
            '{"2000-01-32T00:00:00Z",      1'b1, isots_pkg::StatusRange, 64'sd0, 0},
            '{"2000-01-00T00:00:00Z",      1'b1, isots_pkg::StatusRange, 64'sd0, 0},
            '{"2000-01-01T24:00:00Z",      1'b1, isots_pkg::StatusRange, 64'sd0, 0},
            '{"2000-01-01T00:60:00Z",      1'b1, isots_pkg::StatusRange, 64'sd0, 0},
            '{"2000-01-01T00:00:60Z",      1'b1, isots_pkg::StatusRange, 64'sd0, 0},
            '{"2000-01-01T00:00:00X",      1'b1, isots_pkg::StatusZone, 64'sd0, 0},
            '{"2000-01-01T00:00:00+24:00", 1'b1, isots_pkg::StatusRange, 64'sd0, 0},
            '{"2000-01-01T00:00:00-05:60", 1'b1, isots_pkg::StatusRange, 64'sd0, 0},
            '{"2000-01-01T00:00:00+0a:00", 1'b1, isots_pkg::StatusNonDigit, 64'sd0, 0},
            '{"1970-01-01T00:00:00Zab:cd", 1'b1, isots_pkg::StatusOk, 64'sd0, 0},
            '{"2000-02-29T12:34:56Z0123456789abcdef", 1'b0, isots_pkg::StatusOk, 64'sd0, 0},
            '{"2001-02-31T00:00:00Z",      1'b0, isots_pkg::StatusOk, 64'sd0, 0},
            '{"2100-03-01T00:00:00+05:30", 1'b0, isots_pkg::StatusOk, 64'sd0, 0},
            '{"2024x05y06z07:08:09-01:30", 1'b0, isots_pkg::StatusOk, 64'sd0, 0}
        };
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (i = 0; i < DIR_N; i++) begin
            txt_q.delete();
            for (j = 0; j < dir_tab[i].text.len(); j++)
                txt_q.push_back(dir_tab[i].text[j]);
            pin_en           = dir_tab[i].pinned;
            pin_stamp.status = dir_tab[i].status;
            pin_stamp.utc    = dir_tab[i].utc[isots_pkg::UtcW-1:0];
            pin_stamp.ofs    = dir_tab[i].ofs[isots_pkg::OfsW-1:0];
            gappy            = $urandom_range(0, 1);
            send_text();
        end

        // Hold the result side off while texts keep coming, so the input backs up
        hold_req = 1'b1;
        while (n_bytes < ITEMS) begin
            build_text();
            gappy = ($urandom_range(0, 3) != 0);
            send_text();
        end
        i_in_valid <= 1'b0;

        while (stamp_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("run covered %0d texts in %0d bytes, %0d results checked",
                 n_texts, n_bytes, n_stamps);
        $display("results by status: ok %0d, short %0d, non-digit %0d, range %0d, zone %0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 status_seen[4]);
        if (faults == 0)
            $display("iso8601_timestamp_parser_tb: PASS");
        else
            $display("iso8601_timestamp_parser_tb: FAIL");
        $finish;
    end

endmodule
